### rtl/binary_image_euler_number_defines.svh
// assertion macros shared by the euler number block
// no dependencies; included by modules that carry concurrent checks
`ifndef BINARY_IMAGE_EULER_NUMBER_DEFINES_SVH
`define BINARY_IMAGE_EULER_NUMBER_DEFINES_SVH

// same-cycle implication
`define EUL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EUL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/eul_pkg.sv
// shared types and constants for the euler number block
// no dependencies
package eul_pkg;

  localparam int CFG_W   = 11;
  localparam int COUNT_W = 21;
  localparam int EULER_W = 22;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  // register index codes (byte address bit 2)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // per-pixel control carried from the scan stage to the corner stage
  typedef struct packed {
    logic pixel;
    logic judge;
    logic row_end;
    logic frame_end;
  } eul_tag_t;

endpackage

### rtl/eul_cfg_regs.sv
// frame size registers behind the apb-style configuration port
// depends on eul_pkg
module eul_cfg_regs
  import eul_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output logic [CFG_W-1:0]  frame_width,
  output logic [CFG_W-1:0]  frame_height
);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             wr_en;
  logic             reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_SIZE_RESET;
      height_r <= CFG_SIZE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = {{(32-CFG_W){1'b0}}, width_r};
      REG_FRAME_HEIGHT: cfg_prdata = {{(32-CFG_W){1'b0}}, height_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign frame_width  = width_r;
  assign frame_height = height_r;

endmodule

### rtl/eul_line_mem.sv
// single-port line store, one bit per column, read-first, registered read data
// no dependencies
module eul_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  logic          wdata,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  // old value comes out while the new pixel goes in at the same column
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/eul_scan.sv
// raster position tracking and scan stage register ahead of the corner logic
// depends on eul_pkg
module eul_scan
  import eul_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CW         = 10,
  parameter int RW         = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] frame_width,
  input  logic [CFG_W-1:0] frame_height,
  input  logic             accept,
  input  logic             stall,
  input  logic             pixel,
  output logic [CW-1:0]    col,
  output logic             s1_valid,
  output eul_tag_t         s1_tag
);

  localparam int XA = (CW > RW) ? CW : RW;
  localparam int XB = (XA > CFG_W) ? XA : CFG_W;
  localparam int XW = XB + 1;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          s1_valid_r;
  eul_tag_t      s1_tag_r;

  logic [XW-1:0] w_raw, h_raw, w_eff, h_eff;
  logic          row_end, frame_end;

  assign w_raw = XW'(frame_width);
  assign h_raw = XW'(frame_height);

  // zero acts as one; oversize clamps to MAX_WIDTH (the line store size) or MAX_HEIGHT
  always_comb begin
    if (w_raw == '0)                  w_eff = XW'(1);
    else if (w_raw > XW'(MAX_WIDTH))  w_eff = XW'(MAX_WIDTH);
    else                              w_eff = w_raw;
    if (h_raw == '0)                  h_eff = XW'(1);
    else if (h_raw > XW'(MAX_HEIGHT)) h_eff = XW'(MAX_HEIGHT);
    else                              h_eff = h_raw;
  end

  assign row_end   = XW'(col_r) >= (w_eff - XW'(1));
  assign frame_end = row_end && (XW'(row_r) >= (h_eff - XW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept | (s1_valid_r & stall);
      if (accept) begin
        if (row_end) begin
          col_r <= '0;
          if (frame_end) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag_r.pixel     <= pixel;
      s1_tag_r.judge     <= (row_r != '0) && (col_r != '0);
      s1_tag_r.row_end   <= row_end;
      s1_tag_r.frame_end <= frame_end;
    end
  end

  assign col      = col_r;
  assign s1_valid = s1_valid_r;
  assign s1_tag   = s1_tag_r;

endmodule

### rtl/eul_corner.sv
// corner pattern counting, frame totals and the result output register
// depends on eul_pkg and binary_image_euler_number_defines.svh
`include "binary_image_euler_number_defines.svh"
module eul_corner
  import eul_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  eul_tag_t    s1_tag,
  input  logic        above,
  output logic        stall,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);

  logic               left_r;
  logic               above_left_r;
  logic [COUNT_W-1:0] convex_r;
  logic [COUNT_W-1:0] concave_r;
  logic               out_valid_r;
  logic [EULER_W-1:0] out_euler_r;
  logic [COUNT_W-1:0] out_convex_r;
  logic [COUNT_W-1:0] out_concave_r;

  logic               advance;
  logic               inc_vex, inc_cave;
  logic [COUNT_W-1:0] convex_nxt, concave_nxt;
  logic [EULER_W-1:0] euler_nxt;

  // only a frame-closing pixel needs the output slot
  assign stall   = s1_valid & s1_tag.frame_end & out_valid_r & ~out_tready;
  assign advance = s1_valid & ~stall;

  assign inc_vex  = s1_tag.judge & left_r & ~above_left_r & ~s1_tag.pixel;
  assign inc_cave = s1_tag.judge & left_r & above_left_r & s1_tag.pixel & ~above;

  // saturating counts
  assign convex_nxt  = (inc_vex && convex_r != '1)   ? convex_r + COUNT_W'(1)  : convex_r;
  assign concave_nxt = (inc_cave && concave_r != '1) ? concave_r + COUNT_W'(1) : concave_r;
  assign euler_nxt   = {1'b0, convex_nxt} - {1'b0, concave_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= 1'b0;
      above_left_r <= 1'b0;
      convex_r     <= '0;
      concave_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        left_r       <= s1_tag.row_end ? 1'b0 : s1_tag.pixel;
        above_left_r <= s1_tag.row_end ? 1'b0 : above;
        if (s1_tag.frame_end) begin
          convex_r    <= '0;
          concave_r   <= '0;
          out_valid_r <= 1'b1;
        end else begin
          convex_r  <= convex_nxt;
          concave_r <= concave_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_tag.frame_end) begin
      out_euler_r   <= euler_nxt;
      out_convex_r  <= convex_nxt;
      out_concave_r <= concave_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_concave_r, out_convex_r, out_euler_r};

  `EUL_ASSERT_NXT(a_totals_clear, clk, rst_n, advance && s1_tag.frame_end,
                  convex_r == '0 && concave_r == '0, "totals not cleared after frame end")
  `EUL_ASSERT_NXT(a_convex_mono, clk, rst_n, advance && !s1_tag.frame_end,
                  convex_r >= $past(convex_r), "convex total went backwards mid frame")
  `EUL_ASSERT_IMP(a_euler_diff, clk, rst_n, out_valid_r,
                  out_euler_r == ({1'b0, out_convex_r} - {1'b0, out_concave_r}),
                  "euler number does not match the two counts")

endmodule

### rtl/binary_image_euler_number.sv
// result path: the last pixel passes the scan stage register, then its totals are registered onto out_tvalid
// throughput: one pixel per cycle while no stall holds in_tready low; the line store is read and written once per pixel
// a result held on the output stalls input only when the next frame also closes
// reset: synchronous active-low rst_n clears positions, counts and output valid;
// frame size registers return to 1024; the line store is not cleared
// top level: instantiates eul_cfg_regs, eul_line_mem, eul_scan, eul_corner; uses eul_pkg
module binary_image_euler_number
  import eul_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] pixel, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [21:0] euler_number, [42:22] convex_count,
                                   // [63:43] concave_count
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] frame_width, frame_height;
  logic             accept, stall, s1_valid, above;
  logic [CW-1:0]    col;
  eul_tag_t         s1_tag;

  assign in_tready = ~stall;
  assign accept    = in_tvalid & in_tready;

  eul_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  eul_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .accept       (accept),
    .stall        (stall),
    .pixel        (in_tdata[0]),
    .col          (col),
    .s1_valid     (s1_valid),
    .s1_tag       (s1_tag)
  );

  eul_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line (
    .clk   (clk),
    .en    (accept),
    .addr  (col),
    .wdata (in_tdata[0]),
    .rdata (above)
  );

  eul_corner u_corner (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_tag     (s1_tag),
    .above      (above),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
